FILE: hw/rtl/gra_pkg.sv
// Shared types and constants for the grouped running aggregate.
package gra_pkg;

  localparam int unsigned VAL_W    = 48;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Aggregate modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SUM   = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_COUNT = 3'd2,
    MODE_MIN   = 3'd3,
    MODE_MAX   = 3'd4
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_GRP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_GRP   = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;  // signed
    logic [VAL_W-1:0] divisor;   // unsigned, only the low count bits are used
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;  // signed, truncated toward zero
  } div_rsp_t;

  // Signed 48-bit add with saturation at both limits
  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      return sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return sum[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/gra_in_if.sv
// Input channel: one sample beat with its two group-change flags.
interface gra_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gra_pkg::SAMPLE_W-1:0] sample;
  logic                                reset_group_changed;
  logic                                accumulate_group_changed;

  modport source (output valid, output sample, output reset_group_changed,
                  output accumulate_group_changed, input ready);
  modport sink   (input valid, input sample, input reset_group_changed,
                  input accumulate_group_changed, output ready);
endinterface

FILE: hw/rtl/gra_out_if.sv
// Result channel: one aggregate beat per record.
interface gra_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [gra_pkg::VAL_W-1:0] aggregate;

  modport source (output valid, output aggregate, input ready);
  modport sink   (input valid, input aggregate, output ready);
endinterface

FILE: hw/rtl/gra_cfg_if.sv
// Configuration write channel: register index and write data.
interface gra_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gra_pkg::CFG_IDX_W-1:0]     index;
  logic [gra_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/gra_div.sv
// Bit-serial restoring divider: signed sum over unsigned count, one quotient bit per cycle.
module gra_div #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gra_pkg::div_req_t req,
  output gra_pkg::div_rsp_t rsp
);

  localparam int unsigned VW     = gra_pkg::VAL_W;
  localparam int unsigned STEP_W = $clog2(VW);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [VW-1:0]         quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_BITS+1:0] trial;
  logic                  fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {1'b0, rem_r, quo_r[VW-1]} - {2'b00, dvs_r};
  assign fits  = ~trial[COUNT_BITS+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      // load magnitude of the dividend; -2^47 maps to 2^47 unsigned
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = req.dividend[VW-1];
      quo_nxt  = req.dividend[VW-1] ? (~req.dividend + VW'(1)) : req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor[COUNT_BITS-1:0];
    end else if (busy_r) begin
      // one quotient bit per cycle
      quo_nxt = {quo_r[VW-2:0], fits};
      rem_nxt = fits ? trial[COUNT_BITS-1:0] : {rem_r[COUNT_BITS-2:0], quo_r[VW-1]};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(VW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Sign fix-up of the finished quotient
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + VW'(1)) : quo_r;

endmodule

FILE: hw/rtl/grouped_running_aggregate.sv
// Top level of the grouped running aggregate: state, sequencer and result register.
// Sum, count, minimum and maximum go from the taken beat to ST_EMIT and then into the output register;
//   average first passes ST_DIV_LOAD and ST_DIV_WAIT, where the bit-serial divider gives one quotient bit per cycle.
// A new beat is taken only in ST_IDLE, after the last result was emitted; ST_EMIT waits for a free output register.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n low, synchronous): state, running, config and output-valid registers cleared, first-sample flag set.
module grouped_running_aggregate #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gra_in_if.sink     in_ch,
  gra_out_if.source  out_ch,
  gra_cfg_if.sink    cfg_ch
);

  localparam int unsigned VW = gra_pkg::VAL_W;

  gra_pkg::state_t              state_r, state_nxt;
  logic [gra_pkg::MODE_W-1:0]   aggregate_mode_r;
  logic                         reset_group_used_r;
  logic                         accumulate_group_used_r;

  logic [VW-1:0]                running_value_r, running_value_nxt;
  logic [VW-1:0]                running_sum_r, running_sum_nxt;
  logic [COUNT_BITS-1:0]        sample_count_r, sample_count_nxt;
  logic                         awaiting_first_r, awaiting_first_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [VW-1:0]                out_aggregate_r, out_aggregate_nxt;

  logic                         in_beat;
  logic                         clr_grp;
  logic                         do_acc;
  logic [VW-1:0]                smp_ext;
  logic [VW-1:0]                rv0, rs0;
  logic [COUNT_BITS-1:0]        cnt0;
  logic                         af0;
  logic                         out_free;

  gra_pkg::div_req_t            div_req;
  gra_pkg::div_rsp_t            div_rsp;

  assign in_ch.ready  = (state_r == gra_pkg::ST_IDLE);
  assign in_beat      = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = ~out_valid_r | out_ch.ready;

  // Group handling: reset check first, then accumulate gating
  assign clr_grp = reset_group_used_r & in_ch.reset_group_changed;
  assign do_acc  = ~accumulate_group_used_r | in_ch.accumulate_group_changed;
  assign smp_ext = {{(VW - gra_pkg::SAMPLE_W){in_ch.sample[gra_pkg::SAMPLE_W-1]}}, in_ch.sample};
  assign rv0  = clr_grp ? '0 : running_value_r;
  assign rs0  = clr_grp ? '0 : running_sum_r;
  assign cnt0 = clr_grp ? '0 : sample_count_r;
  assign af0  = clr_grp | awaiting_first_r;

  // Divider operands come from the registered sum and count
  assign div_req.start    = (state_r == gra_pkg::ST_DIV_LOAD);
  assign div_req.dividend = running_sum_r;
  assign div_req.divisor  = VW'(sample_count_r);

  gra_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Sequencer and record update
  always_comb begin
    state_nxt          = state_r;
    running_value_nxt  = running_value_r;
    running_sum_nxt    = running_sum_r;
    sample_count_nxt   = sample_count_r;
    awaiting_first_nxt = awaiting_first_r;
    out_valid_nxt      = out_valid_r & ~out_ch.ready;
    out_aggregate_nxt  = out_aggregate_r;
    unique case (state_r)
      gra_pkg::ST_IDLE: begin
        if (in_beat) begin
          running_value_nxt  = rv0;
          running_sum_nxt    = rs0;
          sample_count_nxt   = cnt0;
          awaiting_first_nxt = af0;
          state_nxt          = gra_pkg::ST_EMIT;
          if (do_acc) begin
            case (aggregate_mode_r)
              gra_pkg::MODE_SUM: begin
                running_value_nxt = gra_pkg::sat_add(rv0, smp_ext);
              end
              gra_pkg::MODE_AVG: begin
                running_sum_nxt = gra_pkg::sat_add(rs0, smp_ext);
                if (~&cnt0) begin
                  sample_count_nxt = cnt0 + COUNT_BITS'(1);
                end
                state_nxt = gra_pkg::ST_DIV_LOAD;
              end
              gra_pkg::MODE_COUNT: begin
                if (rv0 != gra_pkg::VAL_MAX) begin
                  running_value_nxt = rv0 + VW'(1);
                end
              end
              gra_pkg::MODE_MIN: begin
                if (af0 || ($signed(smp_ext) < $signed(rv0))) begin
                  running_value_nxt  = smp_ext;
                  awaiting_first_nxt = 1'b0;
                end
              end
              gra_pkg::MODE_MAX: begin
                if (af0 || ($signed(smp_ext) > $signed(rv0))) begin
                  running_value_nxt  = smp_ext;
                  awaiting_first_nxt = 1'b0;
                end
              end
              default: begin
                // unused modes hold the running value
              end
            endcase
          end
        end
      end
      gra_pkg::ST_DIV_LOAD: begin
        state_nxt = gra_pkg::ST_DIV_WAIT;
      end
      gra_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          running_value_nxt = div_rsp.quotient;
          state_nxt         = gra_pkg::ST_EMIT;
        end
      end
      gra_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_aggregate_nxt = running_value_r;
          state_nxt         = gra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Running state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_value_r  <= '0;
      running_sum_r    <= '0;
      sample_count_r   <= '0;
      awaiting_first_r <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      running_value_r  <= running_value_nxt;
      running_sum_r    <= running_sum_nxt;
      sample_count_r   <= sample_count_nxt;
      awaiting_first_r <= awaiting_first_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    out_aggregate_r <= out_aggregate_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aggregate_mode_r        <= '0;
      reset_group_used_r      <= 1'b0;
      accumulate_group_used_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gra_pkg::CFG_MODE:      aggregate_mode_r        <= cfg_ch.data;
        gra_pkg::CFG_RESET_GRP: reset_group_used_r      <= cfg_ch.data[0];
        gra_pkg::CFG_ACC_GRP:   accumulate_group_used_r <= cfg_ch.data[0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.aggregate = out_aggregate_r;

  // Divider only finishes while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == gra_pkg::ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // Running value untouched while the division runs
  a_value_held_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gra_pkg::ST_DIV_WAIT && !div_rsp.done) |=> $stable(running_value_r))
    else $error("running value changed during division");

  // A free output register takes the running value on emit
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gra_pkg::ST_EMIT && out_free)
      |=> (out_valid_r && out_aggregate_r == $past(running_value_r)))
    else $error("emit did not load the result register");

endmodule
